>>> rtl/selective_repeat_receiver_core_defines.svh
// Assertion macros shared by the selective-repeat receiver RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// No dependencies.
`default_nettype none

package srr_pkg;

  localparam int SEQ_W     = 10;
  localparam int EXP_W     = 11;
  localparam int ACK_W     = 11;
  localparam int CSUM_W    = 16;
  localparam int PAYLOAD_W = 160;
  localparam int WIN_W     = 6;
  localparam int SUM_W     = 13;
  localparam int LIM_W     = 13;
  localparam int VBIT_N    = 64;
  localparam int VIDX_W    = 6;
  localparam int STEP_W    = 3;
  localparam int SUM_STEPS = 5;
  localparam int LANE_W    = 32;
  localparam int DRAIN_W   = 6;
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 184;
  localparam int CFG_ADDR_W = 3;

  localparam logic [ACK_W-1:0]   ACK_SUM_BASE = 11'd97;
  localparam logic [DRAIN_W-1:0] MAX_DRAIN    = 6'd62;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 6'd8;
  localparam logic [EXP_W-1:0]   EXP_CEILING  = 11'd1024;

  // Register index as decoded from the word address bit.
  localparam logic CFG_IDX_WINDOW = 1'b0;

  typedef logic [PAYLOAD_W-1:0] payload_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DLV_WAIT,
    ST_DRAIN_CHK,
    ST_DRAIN_LOAD,
    ST_ACK_WAIT
  } srr_state_t;

  typedef struct packed {
    logic done;
    logic match;
  } srr_sum_stat_t;

endpackage

`default_nettype wire

>>> rtl/srr_sum_unit.sv
// Iterative checksum unit: adds four payload bytes per cycle to a seed.
// Depends on srr_pkg.
`default_nettype none

module srr_sum_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [srr_pkg::SEQ_W-1:0]    seq,
  input  logic [srr_pkg::SEQ_W-1:0]    pkt_ack,
  input  srr_pkg::payload_t            payload,
  input  logic [srr_pkg::CSUM_W-1:0]   csum,
  output srr_pkg::srr_sum_stat_t       stat
);
  import srr_pkg::*;

  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  acc_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [LANE_W-1:0] word;

  // Pick the 32-bit lane for this step.
  always_comb begin
    case (step_r)
      3'd0:    word = payload[31:0];
      3'd1:    word = payload[63:32];
      3'd2:    word = payload[95:64];
      3'd3:    word = payload[127:96];
      3'd4:    word = payload[159:128];
      default: word = '0;
    endcase
  end

  assign acc_nxt = acc_r + SUM_W'(word[7:0]) + SUM_W'(word[15:8])
                 + SUM_W'(word[23:16]) + SUM_W'(word[31:24]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= SUM_W'(seq) + SUM_W'(pkt_ack);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign stat.done  = done_r;
  assign stat.match = (CSUM_W'(acc_r) == csum);

endmodule

`default_nettype wire

>>> rtl/srr_buffer.sv
// Payload store for out-of-order packets, one write and one registered read port.
// Depends on srr_pkg.
`default_nettype none

module srr_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  srr_pkg::payload_t         wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output srr_pkg::payload_t         rd_data
);
  import srr_pkg::*;

  payload_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/selective_repeat_receiver_core.sv
// Selective-repeat ARQ receiver: checksum check, in-order delivery, buffering, acks.
// Depends on srr_pkg, srr_sum_unit, srr_buffer and the assertion macro header.
// A new packet is taken only in the idle state, after every result of the last one,
// ending in its ack, has been taken; result stalls hold the sequencer in its wait states.
// Reset clears the expected number and the 64 valid bits and sets window_size to 8.
`default_nettype none

`include "selective_repeat_receiver_core_defines.svh"

module selective_repeat_receiver_core #(
  parameter int SEQ_SPACE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items. tdata from bit 0: seq_num(10), pkt_ack_num(10), pkt_checksum(16),
  // payload_low(64), payload_mid(64), payload_high(32), 4 zero bits.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srr_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result items. tdata from bit 0: ack_number(11), ack_checksum(11),
  // out_payload_low(64), out_payload_mid(64), out_payload_high(32), 2 zero bits.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [srr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  // tuser: kind (0 delivers a payload, 1 is an ack).
  output logic                              out_tuser,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [srr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import srr_pkg::*;

  localparam int IDX_W = $clog2(SEQ_SPACE);
  localparam logic [LIM_W-1:0] SPACE_LIM = LIM_W'(SEQ_SPACE);

  // Control state.
  srr_state_t         state_r, state_nxt;
  logic [EXP_W-1:0]   expected_r;
  logic [VBIT_N-1:0]  valid_r;
  logic [DRAIN_W-1:0] drain_cnt_r;
  logic [WIN_W-1:0]   window_r;
  logic               out_valid_r;

  // Captured input item.
  logic [SEQ_W-1:0]   seq_r;
  logic [CSUM_W-1:0]  csum_r;
  payload_t           pl_r;

  // Output register.
  logic               out_kind_r;
  logic [ACK_W-1:0]   out_ack_r;
  logic [ACK_W-1:0]   out_acsum_r;
  payload_t           out_pl_r;

  // Sequencer strobes.
  logic               in_acc;
  logic               out_pop;
  logic               ld_ack;
  logic [ACK_W-1:0]   ack_val;
  logic               ld_dlv_in;
  logic               ld_dlv_mem;
  logic               exp_ld_seq;
  logic               exp_inc;
  logic               mem_wr;
  logic               mem_rd;
  logic               vset_seq;
  logic               vclr_seq;
  logic               vclr_exp;
  logic               cnt_clr;

  srr_sum_stat_t      sum_stat;
  payload_t           rd_data;

  logic [EXP_W-1:0]   seq_x;
  logic [EXP_W-1:0]   exp_m1;
  logic               seq_in_space;
  logic               exp_in_space;
  logic               cfg_wr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  assign seq_x        = EXP_W'(seq_r);
  assign exp_m1       = expected_r - 1'b1;
  assign seq_in_space = (LIM_W'(seq_r) < SPACE_LIM);
  assign exp_in_space = (LIM_W'(expected_r) < SPACE_LIM);

  // The checksum adder starts at the accept edge; it seeds itself from the ports and then
  // walks the captured payload one lane at a time.
  srr_sum_unit u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .seq     (in_tdata[9:0]),
    .pkt_ack (in_tdata[19:10]),
    .payload (pl_r),
    .csum    (csum_r),
    .stat    (sum_stat)
  );

  srr_buffer #(
    .DEPTH (SEQ_SPACE)
  ) u_buf (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (IDX_W'(seq_r)),
    .wr_data (pl_r),
    .rd_en   (mem_rd),
    .rd_addr (IDX_W'(expected_r)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer. The decision is taken in the cycle the checksum unit reports done.
  // Buffered packets are always within 63 numbers of the expected one, so the valid
  // bits are kept in a 64-entry ring indexed by the low sequence bits.
  always_comb begin
    state_nxt  = state_r;
    ld_ack     = 1'b0;
    ack_val    = '0;
    ld_dlv_in  = 1'b0;
    ld_dlv_mem = 1'b0;
    exp_ld_seq = 1'b0;
    exp_inc    = 1'b0;
    mem_wr     = 1'b0;
    mem_rd     = 1'b0;
    vset_seq   = 1'b0;
    vclr_seq   = 1'b0;
    vclr_exp   = 1'b0;
    cnt_clr    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_stat.done) begin
          priority if (!sum_stat.match) begin
            // Corrupt packet: re-ack the last in-order number.
            ld_ack    = 1'b1;
            ack_val   = exp_m1;
            state_nxt = ST_ACK_WAIT;
          end else if (seq_x == expected_r && seq_in_space) begin
            // In-order packet: deliver it, then try the buffered successors.
            // A stale valid bit left at this number by a cut-short drain is dropped.
            ld_dlv_in  = 1'b1;
            exp_ld_seq = 1'b1;
            vclr_seq   = 1'b1;
            cnt_clr    = 1'b1;
            state_nxt  = ST_DLV_WAIT;
          end else if (seq_x < expected_r) begin
            // Duplicate: ack it again.
            ld_ack    = 1'b1;
            ack_val   = seq_x;
            state_nxt = ST_ACK_WAIT;
          end else if (!seq_in_space ||
                       seq_x >= expected_r + EXP_W'(window_r)) begin
            // Beyond the window: drop it and re-ack the last in-order number.
            ld_ack    = 1'b1;
            ack_val   = exp_m1;
            state_nxt = ST_ACK_WAIT;
          end else begin
            // Later packet inside the window: buffer and ack it.
            mem_wr    = 1'b1;
            vset_seq  = 1'b1;
            ld_ack    = 1'b1;
            ack_val   = seq_x;
            state_nxt = ST_ACK_WAIT;
          end
        end
      end
      ST_DLV_WAIT: begin
        if (out_pop) begin
          state_nxt = ST_DRAIN_CHK;
        end
      end
      ST_DRAIN_CHK: begin
        if (exp_in_space && valid_r[expected_r[VIDX_W-1:0]] &&
            drain_cnt_r < MAX_DRAIN) begin
          mem_rd    = 1'b1;
          state_nxt = ST_DRAIN_LOAD;
        end else begin
          ld_ack    = 1'b1;
          ack_val   = seq_x;
          state_nxt = ST_ACK_WAIT;
        end
      end
      ST_DRAIN_LOAD: begin
        ld_dlv_mem = 1'b1;
        vclr_exp   = 1'b1;
        exp_inc    = 1'b1;
        state_nxt  = ST_DLV_WAIT;
      end
      ST_ACK_WAIT: begin
        if (out_pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      valid_r     <= '0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exp_ld_seq) begin
        expected_r <= seq_x + 1'b1;
      end else if (exp_inc) begin
        expected_r <= expected_r + 1'b1;
      end
      if (vset_seq) begin
        valid_r[seq_r[VIDX_W-1:0]] <= 1'b1;
      end
      if (vclr_seq) begin
        valid_r[seq_r[VIDX_W-1:0]] <= 1'b0;
      end
      if (vclr_exp) begin
        valid_r[expected_r[VIDX_W-1:0]] <= 1'b0;
      end
      if (cnt_clr) begin
        drain_cnt_r <= '0;
      end else if (exp_inc) begin
        drain_cnt_r <= drain_cnt_r + 1'b1;
      end
      if (ld_ack || ld_dlv_in || ld_dlv_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input capture and output payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      seq_r  <= in_tdata[9:0];
      csum_r <= in_tdata[35:20];
      pl_r   <= in_tdata[195:36];
    end
    if (ld_ack) begin
      out_kind_r  <= 1'b1;
      out_ack_r   <= ack_val;
      out_acsum_r <= ack_val + ACK_SUM_BASE;
      out_pl_r    <= '0;
    end else if (ld_dlv_in) begin
      out_kind_r  <= 1'b0;
      out_ack_r   <= '0;
      out_acsum_r <= '0;
      out_pl_r    <= pl_r;
    end else if (ld_dlv_mem) begin
      out_kind_r  <= 1'b0;
      out_ack_r   <= '0;
      out_acsum_r <= '0;
      out_pl_r    <= rd_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  // The ack is always the final result of a packet.
  assign out_tlast  = out_kind_r;
  assign out_tdata  = {2'b00, out_pl_r, out_acsum_r, out_ack_r};

  // Configuration: one register, window_size, at byte address 0.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_WINDOW) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_WINDOW) ? 32'(window_r) : '0;

  // Checks on the sequencer. The buffer read data is registered, so it is ready in the load
  // state, and the drained delivery shows up on the port right after the load cycle.
  `SRR_ASSERT_IMP(a_idle_no_result, in_tready, !out_tvalid, "result pending while idle")
  `SRR_ASSERT_NXT(a_last_frees_input, out_pop && out_tlast, in_tready, "input blocked after ack")
  `SRR_ASSERT_IMP(a_expected_bound, 1'b1, expected_r <= EXP_CEILING, "expected out of range")
  `SRR_ASSERT_NXT(a_drain_delivers, state_r == ST_DRAIN_LOAD, out_tvalid && !out_tuser && !out_tlast, "no drain delivery")

endmodule

`default_nettype wire
